// ===== rtl/assert_macros.svh =====
// Assertion macros for the stereo projection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SP_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SP_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define SP_ASSERT_RST(name, pre, post, msg) \
  name: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/sp_pkg.sv =====
// Types, constants and helper functions of the stereo projection block.
`timescale 1ns / 1ps
package sp_pkg;

  localparam int DW  = 32;
  localparam int FB  = 16;
  localparam int UW  = DW - 1;
  localparam int PW  = DW + UW;
  localparam int ZW  = 2 * UW;
  localparam int XW  = 2 * DW;
  localparam int NW  = 3 * DW;
  localparam int DVW = 2 * DW;
  localparam int QB  = DW + 4;
  localparam int SW  = DW + 8;
  localparam int NLANE = 9;
  localparam int CFG_IW = 3;

  localparam int L_PUL = 0;
  localparam int L_R6  = 1;
  localparam int L_PV  = 2;
  localparam int L_R7  = 3;
  localparam int L_PUR = 4;
  localparam int L_R8  = 5;
  localparam int L_R4  = 6;
  localparam int L_R5  = 7;
  localparam int L_R9  = 8;

  localparam logic [QB-1:0] MSAT = {1'b1, {(QB-1){1'b0}}};
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  typedef enum logic [CFG_IW-1:0] {
    CFG_FOCAL_U,
    CFG_FOCAL_V,
    CFG_CENTER_U,
    CFG_CENTER_V,
    CFG_BASELINE
  } sp_cfg_e;

  typedef struct packed {
    logic [UW-1:0]        fu;
    logic [UW-1:0]        fv;
    logic signed [DW-1:0] cu;
    logic signed [DW-1:0] cv;
    logic [UW-1:0]        b;
  } sp_cfg_t;

  typedef struct packed {
    logic signed [DW-1:0] mul;
    logic signed [DW-1:0] mvl;
    logic signed [DW-1:0] mur;
    logic signed [DW-1:0] mvr;
  } sp_meas_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
    logic signed [DW-1:0] w;
    sp_meas_t             meas;
  } sp_in_t;

  typedef struct packed {
    logic [PW-1:0] px;
    logic [PW-1:0] py;
    logic [PW-1:0] pw;
    logic [ZW-1:0] zz;
    logic [ZW-1:0] fb;
    logic [DW-1:0] ax;
    logic [UW-1:0] z;
    logic [XW-1:0] xr;
    logic [PW-1:0] xl;
    logic [PW-1:0] xh;
    logic [NW-1:0] nr;
    logic          sx;
    logic          sy;
    logic          wpos;
    logic          xneg;
    logic          bad;
    sp_meas_t      meas;
  } sp_fr_t;

  typedef struct packed {
    logic [DVW-1:0] rem;
    logic [QB-1:0]  lo;
    logic [QB-1:0]  q;
    logic [DVW-1:0] d;
  } sp_dstep_t;

  typedef struct packed {
    logic             sx;
    logic             sy;
    logic             xneg;
    logic             bad;
    logic [NLANE-1:0] ovf;
    sp_meas_t         meas;
  } sp_side_t;

  typedef struct packed {
    logic signed [DW-1:0] err_u_left;
    logic signed [DW-1:0] err_v_left;
    logic signed [DW-1:0] err_u_right;
    logic signed [DW-1:0] err_v_right;
    logic signed [DW-1:0] jac_fu_over_z;
    logic signed [DW-1:0] jac_fv_over_z;
    logic signed [DW-1:0] jac_ul_dz;
    logic signed [DW-1:0] jac_v_dz;
    logic signed [DW-1:0] jac_ur_dz;
    logic signed [DW-1:0] jac_ur_dw;
    logic                 bad_depth;
  } sp_out_t;

  function automatic logic [DW-1:0] sp_abs(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + DW'(1)) : v;
  endfunction

  function automatic sp_dstep_t sp_prep(input logic [NW-1:0] num, input logic [DVW-1:0] div);
    sp_dstep_t s;
    s.rem = DVW'(num >> QB);
    s.lo  = num[QB-1:0];
    s.q   = '0;
    s.d   = div;
    return s;
  endfunction

  function automatic logic sp_ovf(input logic [NW-1:0] num, input logic [DVW-1:0] div);
    return (num >> QB) >= NW'(div);
  endfunction

  function automatic logic [QB-1:0] sp_round(input logic [QB-1:0] q, input logic ovf);
    logic [QB:0] t;
    t = (QB+1)'(q) + (QB+1)'(1);
    return ovf ? MSAT : t[QB:1];
  endfunction

  function automatic logic signed [SW-1:0] sp_sval(input logic [QB-1:0] m, input logic neg);
    logic signed [SW-1:0] v;
    v = signed'(SW'(m));
    return neg ? -v : v;
  endfunction

  function automatic logic signed [DW-1:0] sp_sat(input logic signed [SW-1:0] v);
    logic signed [DW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[DW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[DW-1:0];
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/sp_in_if.sv =====
// Input channel carrying one landmark and its stereo measurement per item.
`timescale 1ns / 1ps
interface sp_in_if;
  logic                         valid;
  logic                         ready;
  logic signed [sp_pkg::DW-1:0] point_x;
  logic signed [sp_pkg::DW-1:0] point_y;
  logic signed [sp_pkg::DW-1:0] point_z;
  logic signed [sp_pkg::DW-1:0] point_w;
  logic signed [sp_pkg::DW-1:0] meas_u_left;
  logic signed [sp_pkg::DW-1:0] meas_v_left;
  logic signed [sp_pkg::DW-1:0] meas_u_right;
  logic signed [sp_pkg::DW-1:0] meas_v_right;

  modport source (output valid, point_x, point_y, point_z, point_w, meas_u_left,
                  meas_v_left, meas_u_right, meas_v_right, input ready);
  modport sink (input valid, point_x, point_y, point_z, point_w, meas_u_left,
                meas_v_left, meas_u_right, meas_v_right, output ready);
endinterface

// ===== rtl/sp_out_if.sv =====
// Result channel carrying the reprojection errors and Jacobian entries per item.
`timescale 1ns / 1ps
interface sp_out_if;
  logic                         valid;
  logic                         ready;
  logic signed [sp_pkg::DW-1:0] err_u_left;
  logic signed [sp_pkg::DW-1:0] err_v_left;
  logic signed [sp_pkg::DW-1:0] err_u_right;
  logic signed [sp_pkg::DW-1:0] err_v_right;
  logic signed [sp_pkg::DW-1:0] jac_fu_over_z;
  logic signed [sp_pkg::DW-1:0] jac_fv_over_z;
  logic signed [sp_pkg::DW-1:0] jac_ul_dz;
  logic signed [sp_pkg::DW-1:0] jac_v_dz;
  logic signed [sp_pkg::DW-1:0] jac_ur_dz;
  logic signed [sp_pkg::DW-1:0] jac_ur_dw;
  logic                         bad_depth;

  modport source (output valid, err_u_left, err_v_left, err_u_right, err_v_right,
                  jac_fu_over_z, jac_fv_over_z, jac_ul_dz, jac_v_dz, jac_ur_dz,
                  jac_ur_dw, bad_depth, input ready);
  modport sink (input valid, err_u_left, err_v_left, err_u_right, err_v_right,
                jac_fu_over_z, jac_fv_over_z, jac_ul_dz, jac_v_dz, jac_ur_dz,
                jac_ur_dw, bad_depth, output ready);
endinterface

// ===== rtl/stereo_projection_error_top.sv =====
// Top level of the stereo projection error and Jacobian pipeline.
//
//   channel  | direction | handshake            | contents
//   in_ch    | in        | valid/ready          | point x y z w, four measured pixels
//   out_ch   | out       | valid/ready          | four errors, six Jacobian terms, bad depth
//   cfg_*    | in        | cfg_we, no readback  | focal lengths, principal point, baseline
//
// One item enters per cycle unless the pipeline stalls as described below. Each item passes
// through four front stages, one prepare stage, a row of 36 division cells
// producing one quotient bit each, a rounding stage and the result register.
// Reset is synchronous and clears the valid bits and loads the default camera model.
// The whole pipeline stalls only when a finished item waits in the last stage while the
// result register is full and not taken; otherwise items keep entering.
`timescale 1ns / 1ps
module stereo_projection_error_top (
  input  logic                         clk,
  input  logic                         rst_n,
  sp_in_if.sink                        in_ch,
  sp_out_if.source                     out_ch,
  input  logic                         cfg_we,
  input  logic [sp_pkg::CFG_IW-1:0]    cfg_idx,
  input  logic [sp_pkg::DW-1:0]        cfg_wdata
);
  import sp_pkg::*;
  `include "assert_macros.svh"

  sp_cfg_t        cfg_r;
  logic           en;
  sp_in_t         in_pl;
  sp_fr_t         s4;
  logic [3:0]     vf_r;
  logic           v5_r;
  logic [QB-1:0]  vc_r;
  logic           vr_r;
  logic           out_valid_r;
  sp_dstep_t      d5_r   [NLANE];
  sp_dstep_t      d5_nxt [NLANE];
  logic [NW-1:0]  num    [NLANE];
  logic [DVW-1:0] div    [NLANE];
  sp_side_t       side_r [QB+1];
  sp_side_t       side0_nxt;
  logic [QB-1:0]  qv     [NLANE];
  logic [QB-1:0]  mag_r  [NLANE];
  sp_side_t       sider_r;
  logic           neg    [NLANE];
  logic signed [SW-1:0] sv [NLANE];
  sp_out_t        out_r;
  sp_out_t        out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fu <= UW'(500) << FB;
      cfg_r.fv <= UW'(500) << FB;
      cfg_r.cu <= DW'(320) << FB;
      cfg_r.cv <= DW'(240) << FB;
      cfg_r.b  <= UW'((12 << FB) / 100);
    end else if (cfg_we) begin
      case (sp_cfg_e'(cfg_idx))
        CFG_FOCAL_U:  cfg_r.fu <= cfg_wdata[UW-1:0];
        CFG_FOCAL_V:  cfg_r.fv <= cfg_wdata[UW-1:0];
        CFG_CENTER_U: cfg_r.cu <= cfg_wdata;
        CFG_CENTER_V: cfg_r.cv <= cfg_wdata;
        CFG_BASELINE: cfg_r.b  <= cfg_wdata[UW-1:0];
        default: ;
      endcase
    end
  end

  assign en          = !(vr_r && out_valid_r && !out_ch.ready);
  assign in_ch.ready = en && rst_n;

  assign in_pl.x        = in_ch.point_x;
  assign in_pl.y        = in_ch.point_y;
  assign in_pl.z        = in_ch.point_z;
  assign in_pl.w        = in_ch.point_w;
  assign in_pl.meas.mul = in_ch.meas_u_left;
  assign in_pl.meas.mvl = in_ch.meas_v_left;
  assign in_pl.meas.mur = in_ch.meas_u_right;
  assign in_pl.meas.mvr = in_ch.meas_v_right;

  sp_front u_front (
    .clk  (clk),
    .en   (en),
    .din  (in_pl),
    .cfg  (cfg_r),
    .s4   (s4)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= '0;
      v5_r <= 1'b0;
      vc_r <= '0;
      vr_r <= 1'b0;
    end else if (en) begin
      vf_r <= {vf_r[2:0], in_ch.valid};
      v5_r <= vf_r[3];
      vc_r <= {vc_r[QB-2:0], v5_r};
      vr_r <= vc_r[QB-1];
    end
  end

  always_comb begin
    num[L_PUL] = NW'(s4.px) << 1;
    div[L_PUL] = DVW'(s4.z);
    num[L_R6]  = NW'(s4.px) << (FB + 1);
    div[L_R6]  = DVW'(s4.zz);
    num[L_PV]  = NW'(s4.py) << 1;
    div[L_PV]  = DVW'(s4.z);
    num[L_R7]  = NW'(s4.py) << (FB + 1);
    div[L_R7]  = DVW'(s4.zz);
    num[L_PUR] = s4.nr << 1;
    div[L_PUR] = DVW'(s4.z) << FB;
    num[L_R8]  = s4.nr << 1;
    div[L_R8]  = DVW'(s4.zz);
    num[L_R4]  = NW'(cfg_r.fu) << (FB + 1);
    div[L_R4]  = DVW'(s4.z);
    num[L_R5]  = NW'(cfg_r.fv) << (FB + 1);
    div[L_R5]  = DVW'(s4.z);
    num[L_R9]  = NW'(s4.fb) << 1;
    div[L_R9]  = DVW'(s4.z);
    side0_nxt.sx   = s4.sx;
    side0_nxt.sy   = s4.sy;
    side0_nxt.xneg = s4.xneg;
    side0_nxt.bad  = s4.bad;
    side0_nxt.meas = s4.meas;
    for (int l = 0; l < NLANE; l++) begin
      d5_nxt[l]         = sp_prep(num[l], div[l]);
      side0_nxt.ovf[l]  = sp_ovf(num[l], div[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        d5_r[l]  <= d5_nxt[l];
        mag_r[l] <= sp_round(qv[l], side_r[QB].ovf[l]);
      end
      side_r[0] <= side0_nxt;
      for (int k = 1; k <= QB; k++) begin
        side_r[k] <= side_r[k-1];
      end
      sider_r <= side_r[QB];
    end
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    sp_div_row u_row (
      .clk (clk),
      .en  (en),
      .din (d5_r[l]),
      .q   (qv[l])
    );
  end

  always_comb begin
    neg[L_PUL] = sider_r.sx;
    neg[L_R6]  = !sider_r.sx;
    neg[L_PV]  = sider_r.sy;
    neg[L_R7]  = !sider_r.sy;
    neg[L_PUR] = sider_r.xneg;
    neg[L_R8]  = !sider_r.xneg;
    neg[L_R4]  = 1'b0;
    neg[L_R5]  = 1'b0;
    neg[L_R9]  = 1'b1;
    for (int l = 0; l < NLANE; l++) begin
      sv[l] = sp_sval(mag_r[l], neg[l]);
    end
    out_nxt = '0;
    if (sider_r.bad) begin
      out_nxt.bad_depth = 1'b1;
    end else begin
      out_nxt.err_u_left  = sp_sat(SW'(sider_r.meas.mul) - SW'(cfg_r.cu) - sv[L_PUL]);
      out_nxt.err_v_left  = sp_sat(SW'(sider_r.meas.mvl) - SW'(cfg_r.cv) - sv[L_PV]);
      out_nxt.err_u_right = sp_sat(SW'(sider_r.meas.mur) - SW'(cfg_r.cu) - sv[L_PUR]);
      out_nxt.err_v_right = sp_sat(SW'(sider_r.meas.mvr) - SW'(cfg_r.cv) - sv[L_PV]);
      out_nxt.jac_fu_over_z = sp_sat(sv[L_R4]);
      out_nxt.jac_fv_over_z = sp_sat(sv[L_R5]);
      out_nxt.jac_ul_dz     = sp_sat(sv[L_R6]);
      out_nxt.jac_v_dz      = sp_sat(sv[L_R7]);
      out_nxt.jac_ur_dz     = sp_sat(sv[L_R8]);
      out_nxt.jac_ur_dw     = sp_sat(sv[L_R9]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (vr_r && en) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vr_r && en) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.err_u_left    = out_r.err_u_left;
  assign out_ch.err_v_left    = out_r.err_v_left;
  assign out_ch.err_u_right   = out_r.err_u_right;
  assign out_ch.err_v_right   = out_r.err_v_right;
  assign out_ch.jac_fu_over_z = out_r.jac_fu_over_z;
  assign out_ch.jac_fv_over_z = out_r.jac_fv_over_z;
  assign out_ch.jac_ul_dz     = out_r.jac_ul_dz;
  assign out_ch.jac_v_dz      = out_r.jac_v_dz;
  assign out_ch.jac_ur_dz     = out_r.jac_ur_dz;
  assign out_ch.jac_ur_dw     = out_r.jac_ur_dw;
  assign out_ch.bad_depth     = out_r.bad_depth;

  `SP_ASSERT_IMPL(a_bad_zero, out_valid_r && out_r.bad_depth, (out_r.jac_fu_over_z == '0) && (out_r.err_u_left == '0) && (out_r.jac_ur_dw == '0), "bad depth item carries nonzero results")
  `SP_ASSERT_IMPL(a_jac_sign, out_valid_r && !out_r.bad_depth, !out_r.jac_fu_over_z[DW-1] && !out_r.jac_fv_over_z[DW-1] && (out_r.jac_ur_dw[DW-1] || (out_r.jac_ur_dw == '0)), "Jacobian focal terms have the wrong sign")
  `SP_ASSERT_NEXT(a_stall_hold, vr_r && !en, vr_r && $stable(mag_r[L_PUL]) && $stable(sider_r), "last stage changed during a stall")
  `SP_ASSERT_RST(a_reset_empty, !rst_n, !out_valid_r && !vr_r && (vc_r == '0), "pipeline not empty after reset")
endmodule

// ===== rtl/sp_div_cell.sv =====
// One restoring division cell that produces a single quotient bit per cycle while en is high.
`timescale 1ns / 1ps
module sp_div_cell (
  input  logic              clk,
  input  logic              en,
  input  sp_pkg::sp_dstep_t din,
  output sp_pkg::sp_dstep_t dout
);
  import sp_pkg::*;

  sp_dstep_t      dout_r;
  sp_dstep_t      dout_nxt;
  logic [DVW-1:0] t;
  logic           ge;

  always_comb begin
    t  = {din.rem[DVW-2:0], din.lo[QB-1]};
    ge = t >= din.d;
    dout_nxt.rem = ge ? (t - din.d) : t;
    dout_nxt.lo  = {din.lo[QB-2:0], 1'b0};
    dout_nxt.q   = {din.q[QB-2:0], ge};
    dout_nxt.d   = din.d;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;
endmodule

// ===== rtl/sp_div_row.sv =====
// A row of division cells that turns one prepared dividend into a full quotient.
`timescale 1ns / 1ps
module sp_div_row (
  input  logic                   clk,
  input  logic                   en,
  input  sp_pkg::sp_dstep_t      din,
  output logic [sp_pkg::QB-1:0]  q
);
  import sp_pkg::*;

  sp_dstep_t st [QB+1];

  assign st[0] = din;

  for (genvar k = 0; k < QB; k++) begin : g_cell
    sp_div_cell u_cell (
      .clk  (clk),
      .en   (en),
      .din  (st[k]),
      .dout (st[k+1])
    );
  end

  assign q = st[QB].q;
endmodule

// ===== rtl/sp_front.sv =====
// Front stages: magnitudes, products and the exact shifted right-camera numerator.
`timescale 1ns / 1ps
module sp_front (
  input  logic            clk,
  input  logic            en,
  input  sp_pkg::sp_in_t  din,
  input  sp_pkg::sp_cfg_t cfg,
  output sp_pkg::sp_fr_t  s4
);
  import sp_pkg::*;

  sp_fr_t s1_r, s1_nxt;
  sp_fr_t s2_r, s2_nxt;
  sp_fr_t s3_r, s3_nxt;
  sp_fr_t s4_r, s4_nxt;
  logic [DW-1:0] ay;
  logic [DW-1:0] aw;
  logic [XW-1:0] xa;
  logic [XW-1:0] xb;

  always_comb begin
    s1_nxt      = '0;
    ay          = sp_abs(din.y);
    aw          = sp_abs(din.w);
    s1_nxt.ax   = sp_abs(din.x);
    s1_nxt.px   = PW'(s1_nxt.ax) * PW'(cfg.fu);
    s1_nxt.py   = PW'(ay) * PW'(cfg.fv);
    s1_nxt.pw   = PW'(aw) * PW'(cfg.b);
    s1_nxt.zz   = ZW'(din.z[UW-1:0]) * ZW'(din.z[UW-1:0]);
    s1_nxt.fb   = ZW'(cfg.fu) * ZW'(cfg.b);
    s1_nxt.z    = din.z[UW-1:0];
    s1_nxt.sx   = din.x[DW-1];
    s1_nxt.sy   = din.y[DW-1];
    s1_nxt.wpos = !din.w[DW-1] && (din.w != '0);
    s1_nxt.bad  = din.z[DW-1] || (din.z == '0);
    s1_nxt.meas = din.meas;
  end

  always_comb begin
    s2_nxt = s1_r;
    xa     = XW'(s1_r.ax) << FB;
    xb     = XW'(s1_r.pw);
    if (s1_r.sx == s1_r.wpos) begin
      s2_nxt.xr   = xa + xb;
      s2_nxt.xneg = s1_r.sx;
    end else if (xa >= xb) begin
      s2_nxt.xr   = xa - xb;
      s2_nxt.xneg = s1_r.sx;
    end else begin
      s2_nxt.xr   = xb - xa;
      s2_nxt.xneg = s1_r.wpos;
    end
  end

  always_comb begin
    s3_nxt    = s2_r;
    s3_nxt.xl = PW'(s2_r.xr[DW-1:0]) * PW'(cfg.fu);
    s3_nxt.xh = PW'(s2_r.xr[XW-1:DW]) * PW'(cfg.fu);
  end

  always_comb begin
    s4_nxt    = s3_r;
    s4_nxt.nr = NW'(s3_r.xl) + (NW'(s3_r.xh) << DW);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
    end
  end

  assign s4 = s4_r;
endmodule
